// ===== rtl/core/idll_pkg.sv =====
// Shared types and constants for the indexed doubly linked list.
package idll_pkg;

    // Node id width, fixed by the stream fields
    localparam int ID_W = 7;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Command kinds, coded as on the slave tuser bits
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_HIDE   = 2'd1,
        OP_LIST   = 2'd2
    } op_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] node;        // reference node for insert, target for hide
        logic            right_side;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_LINK,
        ST_INS_SPLICE,
        ST_LIST_RD,
        ST_LIST_STEP,
        ST_LIST_END
    } st_t;

endpackage

// ===== rtl/core/indexed_doubly_linked_list.sv =====
// Top level of the indexed doubly linked list: front end, command queue and back end.
//
//  channel  | direction | handshake            | contents
//  s_axis   | in        | tvalid/tready        | tuser: action; tdata: ref_node, right_side, target
//  m_axis   | out       | tvalid/tready        | tdata: node_id; tlast: last; tuser: empty_res
//
// An insert passes through a link state and a splice state in the back end, and a hide
// completes in the idle state; a list request reads the link tables through their single
// read port and then steps, for each node walked. A two-word command queue sits in front.
// Reset leaves node 1 as the only list member; no clearing pass is needed.
// A full output register stalls the walk when a further visible id is found,
// and holds the closing word of a run until it drains.
module indexed_doubly_linked_list
#(
    parameter int NODES = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [6:0] ref_node, [7] right_side, [14:8] target, [15] zero
    input  logic [idll_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] action
    input  logic [idll_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [6:0] node_id, [7] zero
    output logic [idll_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,
    // [0] empty_res
    output logic                              m_axis_tuser
);

    logic           cmd_valid;
    logic           cmd_ready;
    idll_pkg::cmd_t cmd;

    idll_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    idll_back #(
        .NODES (NODES)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/core/idll_front.sv =====
// Front end: accepts input words, classifies them and queues commands for the back end.
module idll_front
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [idll_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic [idll_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output idll_pkg::cmd_t                    cmd
);

    idll_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    idll_pkg::cmd_t dec_cmd;
    logic           dec_keep;
    logic           push;
    logic           pop;

    // Classify the incoming word; the unused action code is dropped
    always_comb
    begin
        dec_cmd.op         = idll_pkg::OP_INSERT;
        dec_cmd.node       = s_axis_tdata[6:0];
        dec_cmd.right_side = s_axis_tdata[7];
        dec_keep           = 1'b1;
        case (idll_pkg::op_t'(s_axis_tuser))
            idll_pkg::OP_INSERT:
            begin
                dec_cmd.op = idll_pkg::OP_INSERT;
            end
            idll_pkg::OP_HIDE:
            begin
                dec_cmd.op   = idll_pkg::OP_HIDE;
                dec_cmd.node = s_axis_tdata[14:8];
            end
            idll_pkg::OP_LIST:
            begin
                dec_cmd.op = idll_pkg::OP_LIST;
            end
            default:
            begin
                dec_keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready && dec_keep;
    assign cmd_valid     = (count_reg != 2'd0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = q_reg[rd_ptr_reg];

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

// ===== rtl/core/idll_back.sv =====
// Back end: link tables, hidden flags and the insert, hide and list sequencer.
module idll_back
#(
    parameter int NODES = 64
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  idll_pkg::cmd_t                    cmd,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [idll_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tlast,
    output logic                              m_axis_tuser
);

    localparam int IDX_W = $clog2(NODES + 1);
    localparam int ID_W  = idll_pkg::ID_W;

    // Link tables
    logic [ID_W-1:0] left_mem  [NODES+1];
    logic [ID_W-1:0] right_mem [NODES+1];

    logic             left_we,  right_we;
    logic [IDX_W-1:0] left_wa,  right_wa;
    logic [ID_W-1:0]  left_wd,  right_wd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [ID_W-1:0]  left_rd_reg, right_rd_reg;
    logic             hid_rd_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic [ID_W-1:0]  left_link, right_link;

    // Control state
    idll_pkg::st_t   st_reg, st_next;
    logic [ID_W-1:0] ref_reg, ref_next;
    logic            side_reg, side_next;
    logic [ID_W-1:0] nb_reg, nb_next;
    logic [ID_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] steps_reg, steps_next;
    logic [ID_W-1:0] pend_reg, pend_next;
    logic            have_pend_reg, have_pend_next;
    logic [ID_W-1:0] head_reg, head_next;
    logic [ID_W-1:0] next_id_reg, next_id_next;
    logic            n1l_reg, n1l_next;
    logic            n1r_reg, n1r_next;
    logic [NODES:0]  hidden_reg, hidden_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic            out_last_reg, out_last_next;
    logic            out_empty_reg, out_empty_next;
    logic            out_free;
    logic            out_load;

    logic            present;
    logic            vis;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cmd_ready = (st_reg == idll_pkg::ST_IDLE);

    // Node 1 links read as null until first written
    assign left_link  = (rd_addr_reg == IDX_W'(1) && !n1l_reg) ? '0 : left_rd_reg;
    assign right_link = (rd_addr_reg == IDX_W'(1) && !n1r_reg) ? '0 : right_rd_reg;

    assign present = (cmd.node != '0) && (cmd.node < next_id_reg);
    assign vis     = !hid_rd_reg;

    // Sequence commands
    always_comb
    begin
        st_next        = st_reg;
        ref_next       = ref_reg;
        side_next      = side_reg;
        nb_next        = nb_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        pend_next      = pend_reg;
        have_pend_next = have_pend_reg;
        head_next      = head_reg;
        next_id_next   = next_id_reg;
        n1l_next       = n1l_reg;
        n1r_next       = n1r_reg;
        hidden_next    = hidden_reg;
        left_we        = 1'b0;
        left_wa        = '0;
        left_wd        = '0;
        right_we       = 1'b0;
        right_wa       = '0;
        right_wd       = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        out_load       = 1'b0;
        out_id_next    = out_id_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        case (st_reg)
            idll_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        idll_pkg::OP_INSERT:
                        begin
                            // Drop when full or the reference is absent
                            if (next_id_reg <= ID_W'(NODES) && present)
                            begin
                                ref_next  = cmd.node;
                                side_next = cmd.right_side;
                                rd_en     = 1'b1;
                                rd_addr   = cmd.node[IDX_W-1:0];
                                st_next   = idll_pkg::ST_INS_LINK;
                            end
                        end
                        idll_pkg::OP_HIDE:
                        begin
                            if (present)
                            begin
                                hidden_next[cmd.node[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        idll_pkg::OP_LIST:
                        begin
                            cur_next       = head_reg;
                            steps_next     = '0;
                            have_pend_next = 1'b0;
                            st_next        = idll_pkg::ST_LIST_RD;
                        end
                        default:
                        begin
                            st_next = idll_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            idll_pkg::ST_INS_LINK:
            begin
                // Link the fresh node to its two neighbours
                nb_next  = side_reg ? right_link : left_link;
                left_we  = 1'b1;
                right_we = 1'b1;
                left_wa  = next_id_reg[IDX_W-1:0];
                right_wa = next_id_reg[IDX_W-1:0];
                if (side_reg)
                begin
                    left_wd  = ref_reg;
                    right_wd = right_link;
                end
                else
                begin
                    left_wd  = left_link;
                    right_wd = ref_reg;
                end
                st_next = idll_pkg::ST_INS_SPLICE;
            end

            idll_pkg::ST_INS_SPLICE:
            begin
                // Point the neighbours back at the fresh node
                left_wd  = next_id_reg;
                right_wd = next_id_reg;
                if (side_reg)
                begin
                    right_we = 1'b1;
                    right_wa = ref_reg[IDX_W-1:0];
                    left_we  = (nb_reg != '0);
                    left_wa  = nb_reg[IDX_W-1:0];
                    if (ref_reg == ID_W'(1))
                    begin
                        n1r_next = 1'b1;
                    end
                    if (nb_reg == ID_W'(1))
                    begin
                        n1l_next = 1'b1;
                    end
                end
                else
                begin
                    left_we  = 1'b1;
                    left_wa  = ref_reg[IDX_W-1:0];
                    right_we = (nb_reg != '0);
                    right_wa = nb_reg[IDX_W-1:0];
                    if (ref_reg == ID_W'(1))
                    begin
                        n1l_next = 1'b1;
                    end
                    if (nb_reg == ID_W'(1))
                    begin
                        n1r_next = 1'b1;
                    end
                    if (ref_reg == head_reg)
                    begin
                        head_next = next_id_reg;
                    end
                end
                next_id_next = next_id_reg + ID_W'(1);
                st_next      = idll_pkg::ST_IDLE;
            end

            idll_pkg::ST_LIST_RD:
            begin
                if (cur_reg == '0 || steps_reg == IDX_W'(NODES))
                begin
                    st_next = idll_pkg::ST_LIST_END;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = cur_reg[IDX_W-1:0];
                    st_next = idll_pkg::ST_LIST_STEP;
                end
            end

            idll_pkg::ST_LIST_STEP:
            begin
                // Hold while an earlier visible id waits for the output register
                if (!(vis && have_pend_reg && !out_free))
                begin
                    if (vis)
                    begin
                        if (have_pend_reg)
                        begin
                            out_load       = 1'b1;
                            out_id_next    = pend_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                        end
                        pend_next      = cur_reg;
                        have_pend_next = 1'b1;
                    end
                    cur_next   = right_link;
                    steps_next = steps_reg + IDX_W'(1);
                    st_next    = idll_pkg::ST_LIST_RD;
                end
            end

            idll_pkg::ST_LIST_END:
            begin
                // Close the run, or report an empty list
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_last_next  = 1'b1;
                    out_id_next    = have_pend_reg ? pend_reg : '0;
                    out_empty_next = !have_pend_reg;
                    st_next        = idll_pkg::ST_IDLE;
                end
            end

            default:
            begin
                st_next = idll_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= idll_pkg::ST_IDLE;
            steps_reg     <= '0;
            have_pend_reg <= 1'b0;
            head_reg      <= ID_W'(1);
            next_id_reg   <= ID_W'(2);
            n1l_reg       <= 1'b0;
            n1r_reg       <= 1'b0;
            hidden_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            steps_reg     <= steps_next;
            have_pend_reg <= have_pend_next;
            head_reg      <= head_next;
            next_id_reg   <= next_id_next;
            n1l_reg       <= n1l_next;
            n1r_reg       <= n1r_next;
            hidden_reg    <= hidden_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ref_reg       <= ref_next;
        side_reg      <= side_next;
        nb_reg        <= nb_next;
        cur_reg       <= cur_next;
        pend_reg      <= pend_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    // Link table ports; the hidden flag is read alongside the links
    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[left_wa] <= left_wd;
        end
        if (right_we)
        begin
            right_mem[right_wa] <= right_wd;
        end
        if (rd_en)
        begin
            left_rd_reg  <= left_mem[rd_addr];
            right_rd_reg <= right_mem[rd_addr];
            hid_rd_reg   <= hidden_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_id_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule
